>>> sv/utfq_pkg.sv
// Shared types and constants for the tagged FIFO queue.
// Used by utfq_ctrl, utfq_dp and the top level uid_tagged_fifo_queue.
package utfq_pkg;

  localparam int DEFAULT_DEPTH = 5;
  localparam int TAG_W         = 16;
  localparam int FILL_W        = 6;
  localparam int DROP_W        = 16;
  localparam int POS_W         = 5;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_TAKE_IDX  = 2'd1,
    OP_TAKE_TAG  = 2'd2,
    OP_FIND_TAG  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic [7:0]  species;
    logic [2:0]  rarity;
    logic [31:0] stamp;
    logic [6:0]  health_pct;
    logic        transient;
    logic        special;
  } payload_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;    // capture the command
    logic compare;  // register the tag match vector
    logic advance;  // candidate tag is live, try the next one
    logic commit;   // apply the command and load the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic retry;
  } status_t;

endpackage

>>> sv/utfq_ctrl.sv
// Command sequencer for the tagged FIFO queue.
// Depends on utfq_pkg for the state encoding and command/status structs.
module utfq_ctrl
  import utfq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        if (status.retry) begin
          cmd.advance = 1'b1;
          state_next  = S_CMP;
        end else begin
          cmd.commit  = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

>>> sv/utfq_dp.sv
// Datapath of the tagged FIFO queue: entry registers, tag compare, allocation,
// drop counter and result registers. Depends on utfq_pkg.
module utfq_dp
  import utfq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [1:0]        opcode,
  input  logic [POS_W-1:0]  position,
  input  logic [TAG_W-1:0]  tag,
  input  payload_t          in_pl,
  output logic              ok,
  output logic              evicted,
  output logic [TAG_W-1:0]  out_tag,
  output payload_t          out_pl,
  output logic [FILL_W-1:0] fill,
  output logic [DROP_W-1:0] drop_total
);

  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  op_t                 op_q;
  logic [POS_W-1:0]    pos_q;
  logic [TAG_W-1:0]    tag_q;
  payload_t            pl_q;

  logic [TAG_W-1:0]    entry_tags [DEPTH];
  payload_t            entry_pls  [DEPTH];
  logic [OCC_W-1:0]    occ;
  logic [TAG_W-1:0]    next_tag;
  logic [DROP_W-1:0]   drop_count;
  logic [DEPTH-1:0]    match_q;

  logic [TAG_W-1:0]    cand;
  logic [TAG_W-1:0]    key;
  logic                hit;
  logic [IW-1:0]       hit_idx;
  logic                full;
  logic                sel_ok;
  logic [IW-1:0]       sel_idx;
  logic                do_remove;
  logic [IW-1:0]       rem_idx;
  logic                do_write;
  logic [IW-1:0]       wr_slot;
  logic                is_push;

  assign is_push = (op_q == OP_PUSH);
  // zero is never handed out as a tag
  assign cand    = (next_tag == '0) ? TAG_W'(1) : next_tag;
  assign key     = is_push ? cand : tag_q;
  assign full    = (occ == OCC_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= op_t'(opcode);
      pos_q <= position;
      tag_q <= tag;
      pl_q  <= in_pl;
    end
  end

  // one equality compare per entry, masked to live entries
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_q[i] <= (entry_tags[i] == key) && (OCC_W'(i) < occ);
      end
    end
  end

  always_comb begin
    hit     = |match_q;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = IW'(i);
    end
  end

  assign status.retry = is_push && hit;

  always_comb begin
    sel_ok  = 1'b0;
    sel_idx = hit_idx;
    case (op_q)
      OP_TAKE_IDX: begin
        sel_ok  = (FILL_W'(pos_q) < FILL_W'(occ));
        sel_idx = pos_q[IW-1:0];
      end
      OP_TAKE_TAG, OP_FIND_TAG: begin
        sel_ok  = hit && (tag_q != '0);
        sel_idx = hit_idx;
      end
      default: begin
        sel_ok  = 1'b0;
        sel_idx = hit_idx;
      end
    endcase
  end

  always_comb begin
    do_remove = 1'b0;
    rem_idx   = sel_idx;
    do_write  = 1'b0;
    wr_slot   = occ[IW-1:0];
    if (cmd.commit) begin
      if (is_push) begin
        do_write  = 1'b1;
        do_remove = full;
        rem_idx   = '0;
        wr_slot   = full ? IW'(DEPTH - 1) : occ[IW-1:0];
      end else if (op_q != OP_FIND_TAG) begin
        do_remove = sel_ok;
      end
    end
  end

  // shift younger entries down on removal, then place a pushed entry
  for (genvar k = 0; k < DEPTH; k++) begin : g_ent
    if (k < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (rst) begin
          entry_tags[k] <= '0;
        end else if (do_write && wr_slot == IW'(k)) begin
          entry_tags[k] <= cand;
        end else if (do_remove && IW'(k) >= rem_idx) begin
          entry_tags[k] <= entry_tags[k+1];
        end
      end
      always_ff @(posedge clk) begin
        if (do_write && wr_slot == IW'(k)) begin
          entry_pls[k] <= pl_q;
        end else if (do_remove && IW'(k) >= rem_idx) begin
          entry_pls[k] <= entry_pls[k+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (rst) begin
          entry_tags[k] <= '0;
        end else if (do_write && wr_slot == IW'(k)) begin
          entry_tags[k] <= cand;
        end
      end
      always_ff @(posedge clk) begin
        if (do_write && wr_slot == IW'(k)) begin
          entry_pls[k] <= pl_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      next_tag   <= TAG_W'(1);
      drop_count <= '0;
    end else begin
      if (cmd.advance) begin
        next_tag <= cand + TAG_W'(1);
      end
      if (cmd.commit) begin
        if (is_push) begin
          next_tag <= cand + TAG_W'(1);
          if (full) begin
            if (drop_count != '1) drop_count <= drop_count + DROP_W'(1);
          end else begin
            occ <= occ + OCC_W'(1);
          end
        end else if (do_remove) begin
          occ <= occ - OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (is_push) begin
        ok      <= 1'b1;
        evicted <= full;
        out_tag <= cand;
        out_pl  <= '0;
      end else begin
        evicted <= 1'b0;
        ok      <= sel_ok;
        out_tag <= sel_ok ? entry_tags[sel_idx] : '0;
        out_pl  <= sel_ok ? entry_pls[sel_idx] : '0;
      end
    end
  end

  assign fill       = FILL_W'(occ);
  assign drop_total = drop_count;

endmodule

>>> sv/uid_tagged_fifo_queue.sv
// Top level of the bounded FIFO with unique nonzero tags.
// Depends on utfq_pkg, utfq_ctrl and utfq_dp.
//
// A command is taken when start is high and busy is low, and its result
// appears for one cycle with done high; the receiver cannot stall it, so
// sample the outputs in that cycle. Every command passes through a
// compare state and an evaluate state before done; each live tag a push
// has to skip adds another compare/evaluate pass, because the tag search
// compares one candidate against all live entries per pass. fill and
// drop_total always show the current queue state.
module uid_tagged_fifo_queue
  import utfq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  logic [1:0]        opcode,
  input  logic [POS_W-1:0]  position,
  input  logic [TAG_W-1:0]  tag,
  input  logic [7:0]        species,
  input  logic [2:0]        rarity,
  input  logic [31:0]       stamp,
  input  logic [6:0]        health_pct,
  input  logic              transient,
  input  logic              special,
  output logic              ok,
  output logic              evicted,
  output logic [TAG_W-1:0]  out_tag,
  output logic [7:0]        out_species,
  output logic [2:0]        out_rarity,
  output logic [31:0]       out_stamp,
  output logic [6:0]        out_health_pct,
  output logic              out_transient,
  output logic              out_special,
  output logic [FILL_W-1:0] fill,
  output logic [DROP_W-1:0] drop_total
);

  cmd_t     cmd;
  status_t  status;
  payload_t in_pl;
  payload_t out_pl;

  assign in_pl.species    = species;
  assign in_pl.rarity     = rarity;
  assign in_pl.stamp      = stamp;
  assign in_pl.health_pct = health_pct;
  assign in_pl.transient  = transient;
  assign in_pl.special    = special;

  assign out_species    = out_pl.species;
  assign out_rarity     = out_pl.rarity;
  assign out_stamp      = out_pl.stamp;
  assign out_health_pct = out_pl.health_pct;
  assign out_transient  = out_pl.transient;
  assign out_special    = out_pl.special;

  utfq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  utfq_dp #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .opcode     (opcode),
    .position   (position),
    .tag        (tag),
    .in_pl      (in_pl),
    .ok         (ok),
    .evicted    (evicted),
    .out_tag    (out_tag),
    .out_pl     (out_pl),
    .fill       (fill),
    .drop_total (drop_total)
  );

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // a transfer into the block makes it busy until its result is out
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not hold busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(QUEUE_DEPTH))
    else $error("fill exceeds queue depth");

  // an eviction only happens on a full queue
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> (ok && fill == FILL_W'(QUEUE_DEPTH)))
    else $error("eviction reported on a queue that is not full");

  a_drop_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (drop_total >= $past(drop_total)))
    else $error("drop counter decreased");

endmodule
